// ===== src/battery_level_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// battery_level_classifier assertion macros
// Clocked assertion shorthands, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_CLASSIFIER_ASSERT_SVH
`define BATTERY_LEVEL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define BLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/blc_pkg.sv =====
// ----------------------------------------------------------------------------
// blc_pkg
// Widths, register indexes, level codes and grading functions of the
// battery level classifier.
// ----------------------------------------------------------------------------
package blc_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int LIMIT_BITS    = 10;
    localparam int LEVEL_BITS    = 4;
    localparam int WINDOW        = 5;
    localparam int REPORT_PERIOD = 10;
    localparam int SLOT_BITS     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_BITS    = $clog2(REPORT_PERIOD + 1);
    localparam int SUM_BITS      = ((SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS)
                                   + $clog2(WINDOW + 1);
    localparam int CFG_IDX_BITS  = 3;

    typedef logic signed [LEVEL_BITS-1:0] t_level;
    typedef logic [LIMIT_BITS-1:0]        t_limit;
    typedef logic [SUM_BITS-1:0]          t_sum;
    typedef logic [CFG_IDX_BITS-1:0]      t_cfg_idx;

    // Register indexes
    localparam t_cfg_idx CFG_START_L0 = 3'd0;
    localparam t_cfg_idx CFG_START_L1 = 3'd1;
    localparam t_cfg_idx CFG_RUN_L0   = 3'd2;
    localparam t_cfg_idx CFG_L2       = 3'd3;
    localparam t_cfg_idx CFG_L3       = 3'd4;
    localparam t_cfg_idx CFG_L4       = 3'd5;

    // Reset values of the thresholds
    localparam t_limit RST_START_L0 = 10'd834;
    localparam t_limit RST_START_L1 = 10'd850;
    localparam t_limit RST_RUN_L0   = 10'd838;
    localparam t_limit RST_L2       = 10'd874;
    localparam t_limit RST_L3       = 10'd900;
    localparam t_limit RST_L4       = 10'd924;

    // Level codes
    localparam t_level LEVEL_UNKNOWN = -4'sd1;
    localparam t_level LEVEL0        = 4'sd0;
    localparam t_level LEVEL1        = 4'sd1;
    localparam t_level LEVEL2        = 4'sd2;
    localparam t_level LEVEL3        = 4'sd3;
    localparam t_level LEVEL4        = 4'sd4;
    localparam t_level LEVEL5        = 4'sd5;

    typedef struct packed {
        t_limit start_l0;
        t_limit start_l1;
        t_limit run_l0;
        t_limit l2;
        t_limit l3;
        t_limit l4;
    } t_limits;

    typedef struct packed {
        t_level level;
        logic   changed;
    } t_result;

    // avg < limit is the same as sum < limit * WINDOW for a truncated average
    function automatic t_sum scale_limit(input t_limit l);
        return SUM_BITS'(l) * SUM_BITS'(WINDOW);
    endfunction

    function automatic t_level grade_tail(input t_sum v, input t_sum l2,
                                          input t_sum l3, input t_sum l4);
        t_level lv;
        if (v < l2) begin
            lv = LEVEL2;
        end else if (v < l3) begin
            lv = LEVEL3;
        end else if (v < l4) begin
            lv = LEVEL4;
        end else begin
            lv = LEVEL5;
        end
        return lv;
    endfunction

    function automatic t_level grade_start(input logic [SAMPLE_BITS-1:0] s,
                                           input t_limits lim);
        t_sum   v;
        t_level lv;
        v = SUM_BITS'(s);
        if (v < SUM_BITS'(lim.start_l0)) begin
            lv = LEVEL0;
        end else if (v < SUM_BITS'(lim.start_l1)) begin
            lv = LEVEL1;
        end else begin
            lv = grade_tail(v, SUM_BITS'(lim.l2), SUM_BITS'(lim.l3), SUM_BITS'(lim.l4));
        end
        return lv;
    endfunction

    function automatic t_level grade_run(input t_sum sum, input t_limits lim);
        t_level lv;
        if (sum < scale_limit(lim.run_l0)) begin
            lv = LEVEL0;
        end else begin
            lv = grade_tail(sum, scale_limit(lim.l2), scale_limit(lim.l3),
                            scale_limit(lim.l4));
        end
        return lv;
    endfunction

endpackage

// ===== src/blc_channels.sv =====
// ----------------------------------------------------------------------------
// blc channels
// Valid/ready channels of the battery level classifier: samples in,
// results out, threshold register writes.
// ----------------------------------------------------------------------------
interface blc_sample_if;
    logic                             valid;
    logic                             ready;
    logic [blc_pkg::SAMPLE_BITS-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface blc_result_if;
    logic            valid;
    logic            ready;
    blc_pkg::t_level level;
    logic            changed;

    modport source (output valid, output level, output changed, input ready);
    modport sink   (input valid, input level, input changed, output ready);
endinterface

interface blc_cfg_if;
    logic              valid;
    logic              ready;
    blc_pkg::t_cfg_idx index;
    blc_pkg::t_limit   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/blc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// blc_cfg_regs
// Threshold register bank; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module blc_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    blc_cfg_if.sink          i_cfg_ch,
    output blc_pkg::t_limits o_limits
);

    blc_pkg::t_limits r_limits;

    assign i_cfg_ch.ready = 1'b1;
    assign o_limits       = r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.start_l0 <= blc_pkg::RST_START_L0;
            r_limits.start_l1 <= blc_pkg::RST_START_L1;
            r_limits.run_l0   <= blc_pkg::RST_RUN_L0;
            r_limits.l2       <= blc_pkg::RST_L2;
            r_limits.l3       <= blc_pkg::RST_L3;
            r_limits.l4       <= blc_pkg::RST_L4;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                blc_pkg::CFG_START_L0: r_limits.start_l0 <= i_cfg_ch.data;
                blc_pkg::CFG_START_L1: r_limits.start_l1 <= i_cfg_ch.data;
                blc_pkg::CFG_RUN_L0:   r_limits.run_l0   <= i_cfg_ch.data;
                blc_pkg::CFG_L2:       r_limits.l2       <= i_cfg_ch.data;
                blc_pkg::CFG_L3:       r_limits.l3       <= i_cfg_ch.data;
                blc_pkg::CFG_L4:       r_limits.l4       <= i_cfg_ch.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== src/blc_window.sv =====
// ----------------------------------------------------------------------------
// blc_window
// Sample ring, grading period counter and held level. Computes the result
// of one sample and commits the state on a step.
// ----------------------------------------------------------------------------
module blc_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [blc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  blc_pkg::t_limits                i_limits,
    output blc_pkg::t_result                o_result
);

    logic [blc_pkg::SAMPLE_BITS-1:0] r_store [blc_pkg::WINDOW];
    logic [blc_pkg::SLOT_BITS-1:0]   r_slot;
    logic [blc_pkg::SLOT_BITS-1:0]   n_slot;
    logic [blc_pkg::COUNT_BITS-1:0]  r_count;
    logic [blc_pkg::COUNT_BITS-1:0]  n_count;
    blc_pkg::t_level                 r_held;
    blc_pkg::t_level                 n_held;
    logic                            n_changed;
    logic                            w_known;
    logic                            w_period_hit;
    blc_pkg::t_sum                   w_sum;
    blc_pkg::t_level                 w_run_level;

    assign w_known = (r_held != blc_pkg::LEVEL_UNKNOWN);

    // Ring sum with the incoming sample already in its slot
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < blc_pkg::WINDOW; i++) begin
            if (blc_pkg::SLOT_BITS'(i) == r_slot) begin
                w_sum = w_sum + blc_pkg::SUM_BITS'(i_sample);
            end else begin
                w_sum = w_sum + blc_pkg::SUM_BITS'(r_store[i]);
            end
        end
    end

    assign w_run_level  = blc_pkg::grade_run(w_sum, i_limits);
    assign n_count      = r_count + 1'b1;
    assign w_period_hit = (n_count >= blc_pkg::COUNT_BITS'(blc_pkg::REPORT_PERIOD));
    assign n_slot       = (r_slot == blc_pkg::SLOT_BITS'(blc_pkg::WINDOW - 1))
                          ? '0 : r_slot + 1'b1;

    always_comb begin
        n_held    = r_held;
        n_changed = 1'b0;
        if (!w_known) begin
            n_held = blc_pkg::grade_start(i_sample, i_limits);
        end else if (w_period_hit) begin
            n_held    = w_run_level;
            n_changed = (w_run_level != r_held);
        end
    end

    assign o_result.level   = n_held;
    assign o_result.changed = n_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < blc_pkg::WINDOW; i++) begin
                r_store[i] <= '0;
            end
            r_slot  <= '0;
            r_count <= '0;
            r_held  <= blc_pkg::LEVEL_UNKNOWN;
        end else if (i_step) begin
            r_held <= n_held;
            // the first sample only sets the level
            if (w_known) begin
                for (int i = 0; i < blc_pkg::WINDOW; i++) begin
                    if (blc_pkg::SLOT_BITS'(i) == r_slot) begin
                        r_store[i] <= i_sample;
                    end
                end
                r_slot  <= n_slot;
                r_count <= w_period_hit ? '0 : n_count;
            end
        end
    end

endmodule

// ===== src/battery_level_classifier.sv =====
// Pipeline: the input register takes the sample on its transfer; the result
// register takes its grade when it frees up, so a result-side stall can delay it.
// Throughput: one sample per cycle while the result side is ready; the grading
// logic between the two registers is combinational.
// Reset (i_rst_n low, synchronous): level unknown, ring and counters cleared,
// thresholds back to their defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
// battery_level_classifier
// Grades battery ADC samples into a level from 0 to 5 and flags a change of
// level at each periodic grading.
// ----------------------------------------------------------------------------
`include "battery_level_classifier_assert.svh"

module battery_level_classifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    blc_sample_if.sink   i_sample_ch,
    blc_result_if.source o_result_ch,
    blc_cfg_if.sink      i_cfg_ch
);

    blc_pkg::t_limits                w_limits;
    blc_pkg::t_result                w_result;
    logic                            r_in_valid;
    logic [blc_pkg::SAMPLE_BITS-1:0] r_in_sample;
    logic                            r_out_valid;
    blc_pkg::t_result                r_out;
    logic                            w_advance;
    logic                            w_in_xfer;

    blc_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .o_limits (w_limits)
    );

    blc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_sample (r_in_sample),
        .i_limits (w_limits),
        .o_result (w_result)
    );

    // Move the held sample into the result register when that slot frees up
    assign w_advance         = r_in_valid && (!r_out_valid || o_result_ch.ready);
    assign i_sample_ch.ready = !r_in_valid || !r_out_valid || o_result_ch.ready;
    assign w_in_xfer         = i_sample_ch.valid && i_sample_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_sample <= i_sample_ch.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_result_ch.valid   = r_out_valid;
    assign o_result_ch.level   = r_out.level;
    assign o_result_ch.changed = r_out.changed;

    `BLC_ASSERT_NOW(a_step_level_known, w_advance,
        w_result.level != blc_pkg::LEVEL_UNKNOWN, "graded level is unknown")
    `BLC_ASSERT_NOW(a_change_is_run_level, o_result_ch.valid && o_result_ch.changed,
        o_result_ch.level != blc_pkg::LEVEL1 && o_result_ch.level != blc_pkg::LEVEL_UNKNOWN,
        "flagged change carries a level the periodic grading cannot give")
    `BLC_ASSERT_NEXT(a_in_hold, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in_sample), "blocked input register lost its sample")
    `BLC_ASSERT_NOW(a_full_blocks_input, r_in_valid && r_out_valid && !o_result_ch.ready,
        !i_sample_ch.ready, "input taken while both registers are full and stalled")

endmodule

// ===== tb/tb_battery_level_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_battery_level_classifier
// Drives ADC samples and threshold writes into the battery level classifier,
// grades every accepted sample with a local copy of the level logic and
// compares each result transfer with the oldest pending grade. Both
// handshakes idle at random, except in the last threshold setting.
// ----------------------------------------------------------------------------
module tb_battery_level_classifier;

    localparam int          HALF_PERIOD  = 5;
    localparam int          RESET_CYCLES = 9;
    localparam int          DRAIN_CYCLES = 8;
    localparam longint      TIMEOUT_NS   = 5_000_000;
    localparam int unsigned SAMPLE_MAX   = (1 << blc_pkg::SAMPLE_BITS) - 1;

    // Indexes past the last threshold; writes to them must be dropped
    localparam blc_pkg::t_cfg_idx CFG_SPARE6 = 3'd6;
    localparam blc_pkg::t_cfg_idx CFG_SPARE7 = 3'd7;

    typedef enum {
        SET_DEFAULT, SET_ZERO, SET_FULL, SET_TYPICAL, SET_SORTED, SET_SHUFFLED
    } t_setting;

    typedef enum {WIN_FLAT, WIN_JITTER, WIN_WIDE, WIN_EDGES} t_window_kind;

    logic i_clk;
    logic i_rst_n;

    blc_sample_if smp_ch ();
    blc_result_if res_ch ();
    blc_cfg_if    cfg_ch ();

    battery_level_classifier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch),
        .i_cfg_ch    (cfg_ch)
    );

    // Local copy of the classifier state
    blc_pkg::t_limits                lim_model;
    logic [blc_pkg::SAMPLE_BITS-1:0] ring_model [blc_pkg::WINDOW];
    int unsigned                     ring_slot;
    int unsigned                     since_grading;
    blc_pkg::t_level                 held_model;
    blc_pkg::t_result                expected_results [$];

    int unsigned error_count;
    int unsigned samples_sent;
    int unsigned level_changes;
    int unsigned settings_loaded;
    int unsigned limit_writes;
    int unsigned gap_pct;
    int unsigned stall_pct;

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic blc_pkg::t_level tail_level(input int unsigned v);
        if (v < lim_model.l2) return blc_pkg::LEVEL2;
        if (v < lim_model.l3) return blc_pkg::LEVEL3;
        if (v < lim_model.l4) return blc_pkg::LEVEL4;
        return blc_pkg::LEVEL5;
    endfunction

    // Advance the local state by one sample and return the result it causes
    function automatic blc_pkg::t_result grade_sample(
        input logic [blc_pkg::SAMPLE_BITS-1:0] s);
        blc_pkg::t_result r;
        int unsigned      mean;
        blc_pkg::t_level  lv;
        r.changed = 1'b0;
        mean      = 0;
        if (held_model == blc_pkg::LEVEL_UNKNOWN) begin
            if (s < lim_model.start_l0) begin
                held_model = blc_pkg::LEVEL0;
            end else if (s < lim_model.start_l1) begin
                held_model = blc_pkg::LEVEL1;
            end else begin
                held_model = tail_level(s);
            end
        end else begin
            ring_model[ring_slot] = s;
            ring_slot = (ring_slot + 1) % blc_pkg::WINDOW;
            since_grading++;
            if (since_grading >= blc_pkg::REPORT_PERIOD) begin
                since_grading = 0;
                foreach (ring_model[i]) mean += ring_model[i];
                mean = mean / blc_pkg::WINDOW;
                lv = (mean < lim_model.run_l0) ? blc_pkg::LEVEL0 : tail_level(mean);
                if (lv != held_model) begin
                    held_model = lv;
                    r.changed  = 1'b1;
                end
            end
        end
        r.level = held_model;
        return r;
    endfunction

    function automatic int unsigned clamp_sample(input int v);
        if (v < 0) return 0;
        if (v > int'(SAMPLE_MAX)) return SAMPLE_MAX;
        return v;
    endfunction

    function automatic int unsigned pick_run_limit();
        case ($urandom_range(0, 3))
            0:       return lim_model.run_l0;
            1:       return lim_model.l2;
            2:       return lim_model.l3;
            default: return lim_model.l4;
        endcase
    endfunction

    function automatic blc_pkg::t_limits make_setting(input t_setting kind);
        blc_pkg::t_limits l;
        int unsigned      v [$];
        int unsigned      lo;
        int unsigned      hi;
        l  = '0;
        lo = (kind == SET_TYPICAL) ? 780 : 0;
        hi = (kind == SET_TYPICAL) ? 980 : SAMPLE_MAX;
        case (kind)
            SET_DEFAULT: begin
                l.start_l0 = blc_pkg::RST_START_L0;
                l.start_l1 = blc_pkg::RST_START_L1;
                l.run_l0   = blc_pkg::RST_RUN_L0;
                l.l2       = blc_pkg::RST_L2;
                l.l3       = blc_pkg::RST_L3;
                l.l4       = blc_pkg::RST_L4;
            end
            SET_ZERO: l = '0;
            SET_FULL: l = '1;
            SET_SHUFFLED: begin
                l.start_l0 = blc_pkg::t_limit'($urandom_range(0, SAMPLE_MAX));
                l.start_l1 = blc_pkg::t_limit'($urandom_range(0, SAMPLE_MAX));
                l.run_l0   = blc_pkg::t_limit'($urandom_range(0, SAMPLE_MAX));
                l.l2       = blc_pkg::t_limit'($urandom_range(0, SAMPLE_MAX));
                l.l3       = blc_pkg::t_limit'($urandom_range(0, SAMPLE_MAX));
                l.l4       = blc_pkg::t_limit'($urandom_range(0, SAMPLE_MAX));
            end
            default: begin
                repeat (6) v.push_back($urandom_range(lo, hi));
                v.sort();
                l.start_l0 = blc_pkg::t_limit'(v[0]);
                l.run_l0   = blc_pkg::t_limit'(v[1]);
                l.start_l1 = blc_pkg::t_limit'(v[2]);
                l.l2       = blc_pkg::t_limit'(v[3]);
                l.l3       = blc_pkg::t_limit'(v[4]);
                l.l4       = blc_pkg::t_limit'(v[5]);
            end
        endcase
        return l;
    endfunction

    // Result check, threshold tracking and prediction at each rising edge
    always @(posedge i_clk) begin : scoreboard
        blc_pkg::t_result want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $error("result: expected none, actual level %0d changed %0b",
                           res_ch.level, res_ch.changed);
                end else begin
                    want = expected_results.pop_front();
                    if (want.changed) level_changes++;
                    if (res_ch.level !== want.level) begin
                        error_count++;
                        $error("level: expected %0d, actual %0d", want.level, res_ch.level);
                    end
                    if (res_ch.changed !== want.changed) begin
                        error_count++;
                        $error("changed: expected %0b, actual %0b",
                               want.changed, res_ch.changed);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                limit_writes++;
                case (cfg_ch.index)
                    blc_pkg::CFG_START_L0: lim_model.start_l0 = cfg_ch.data;
                    blc_pkg::CFG_START_L1: lim_model.start_l1 = cfg_ch.data;
                    blc_pkg::CFG_RUN_L0:   lim_model.run_l0   = cfg_ch.data;
                    blc_pkg::CFG_L2:       lim_model.l2       = cfg_ch.data;
                    blc_pkg::CFG_L3:       lim_model.l3       = cfg_ch.data;
                    blc_pkg::CFG_L4:       lim_model.l4       = cfg_ch.data;
                    default: ;
                endcase
            end
            if (smp_ch.valid && smp_ch.ready) begin
                samples_sent++;
                expected_results.push_back(grade_sample(smp_ch.sample));
            end
        end
    end

    // Result side: hold ready low in random bursts
    initial begin
        forever begin
            if ($urandom_range(0, 99) < stall_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic [blc_pkg::SAMPLE_BITS-1:0] s);
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        do @(posedge i_clk); while (!smp_ch.ready);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < gap_pct) begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    task automatic write_limit(input blc_pkg::t_cfg_idx idx, input blc_pkg::t_limit value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_until_drained();
        smp_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic load_limits(input blc_pkg::t_limits l);
        if ($urandom_range(0, 1)) write_limit(CFG_SPARE6, blc_pkg::t_limit'($urandom()));
        write_limit(blc_pkg::CFG_START_L0, l.start_l0);
        write_limit(blc_pkg::CFG_START_L1, l.start_l1);
        write_limit(blc_pkg::CFG_RUN_L0, l.run_l0);
        write_limit(blc_pkg::CFG_L2, l.l2);
        write_limit(blc_pkg::CFG_L3, l.l3);
        write_limit(blc_pkg::CFG_L4, l.l4);
        if ($urandom_range(0, 1)) write_limit(CFG_SPARE7, blc_pkg::t_limit'($urandom()));
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        settings_loaded++;
    endtask

    // Fill up to the next grading; the last WINDOW samples follow one pattern (all random if wide)
    task automatic send_window();
        t_window_kind kind;
        int unsigned  pick;
        int unsigned  pivot;
        int unsigned  flat_value;
        int unsigned  count;
        int unsigned  s;
        pick  = $urandom_range(0, 99);
        kind  = (pick < 35) ? WIN_FLAT : (pick < 70) ? WIN_JITTER :
                (pick < 90) ? WIN_WIDE : WIN_EDGES;
        pivot = pick_run_limit();
        flat_value = clamp_sample(int'(pivot) + int'($urandom_range(0, 2)) - 1);
        count = blc_pkg::REPORT_PERIOD - since_grading;
        for (int unsigned k = 0; k < count; k++) begin
            if (k + blc_pkg::WINDOW < count || kind == WIN_WIDE) begin
                s = $urandom_range(0, SAMPLE_MAX);
            end else if (kind == WIN_FLAT) begin
                s = flat_value;
            end else if (kind == WIN_JITTER) begin
                s = clamp_sample(int'(pivot) + int'($urandom_range(0, 12)) - 6);
            end else begin
                case ($urandom_range(0, 2))
                    0:       s = 0;
                    1:       s = SAMPLE_MAX;
                    default: s = $urandom() & SAMPLE_MAX;
                endcase
            end
            send_sample(blc_pkg::SAMPLE_BITS'(s));
        end
    endtask

    // The only start-up grading of the run: exactly at the top threshold
    task automatic test_first_sample();
        send_sample(blc_pkg::RST_L4);
    endtask

    task automatic test_extreme_windows();
        repeat (blc_pkg::REPORT_PERIOD) send_sample('0);
        repeat (blc_pkg::REPORT_PERIOD) send_sample(blc_pkg::SAMPLE_BITS'(SAMPLE_MAX));
    endtask

    task automatic test_unknown_index();
        wait_until_drained();
        write_limit(CFG_SPARE6, '0);
        write_limit(CFG_SPARE7, '1);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        repeat (blc_pkg::REPORT_PERIOD) send_sample(blc_pkg::RST_L4 - 1'b1);
    endtask

    task automatic test_threshold_phase(input t_setting kind, input int windows,
                                        input bit quiet);
        wait_until_drained();
        load_limits(make_setting(kind));
        if (quiet) begin
            gap_pct   = 0;
            stall_pct = 0;
        end else begin
            gap_pct   = $urandom_range(0, 3) * 10;
            stall_pct = $urandom_range(0, 3) * 8;
        end
        repeat (windows) begin
            // Shift the grading phase now and then
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, blc_pkg::REPORT_PERIOD - 1))
                    send_sample(blc_pkg::SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
            end
            send_window();
        end
    endtask

    initial begin
        error_count     = 0;
        samples_sent    = 0;
        level_changes   = 0;
        settings_loaded = 0;
        limit_writes    = 0;
        gap_pct         = 20;
        stall_pct       = 15;
        ring_slot       = 0;
        since_grading   = 0;
        held_model      = blc_pkg::LEVEL_UNKNOWN;
        lim_model       = make_setting(SET_DEFAULT);
        foreach (ring_model[i]) ring_model[i] = '0;

        i_rst_n       <= 1'b0;
        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= blc_pkg::CFG_START_L0;
        cfg_ch.data   <= '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_sample();
        test_extreme_windows();
        test_unknown_index();
        test_threshold_phase(SET_DEFAULT, 30, 1'b0);
        test_threshold_phase(SET_ZERO, 30, 1'b0);
        test_threshold_phase(SET_FULL, 30, 1'b0);
        test_threshold_phase(SET_TYPICAL, 30, 1'b0);
        test_threshold_phase(SET_SHUFFLED, 30, 1'b0);
        test_threshold_phase(SET_SORTED, 30, 1'b0);
        test_threshold_phase(SET_TYPICAL, 30, 1'b1);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d samples under %0d threshold settings, %0d register writes.",
                 samples_sent, settings_loaded, limit_writes);
        $display("Periodic grading flagged %0d level changes.", level_changes);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/blc_pkg.sv
src/blc_channels.sv
src/blc_cfg_regs.sv
src/blc_window.sv
src/battery_level_classifier.sv
tb/tb_battery_level_classifier.sv
